/* rtl/tcm_pkg.sv */
package tcm_pkg;

  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 30;
  localparam int STAT_W    = 32;
  localparam int NUM_STATS = 13;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_STAT  = 2'd2;

  localparam logic [1:0] VIC_NONE  = 2'd0;
  localparam logic [1:0] VIC_CLEAN = 2'd1;
  localparam logic [1:0] VIC_DIRTY = 2'd2;

  localparam logic [3:0] ST_TOTAL     = 4'd0;
  localparam logic [3:0] ST_READS     = 4'd1;
  localparam logic [3:0] ST_WRITES    = 4'd2;
  localparam logic [3:0] ST_L1_RD_MIS = 4'd3;
  localparam logic [3:0] ST_L1_WR_MIS = 4'd4;
  localparam logic [3:0] ST_L1_CLEAN  = 4'd5;
  localparam logic [3:0] ST_L1_DIRTY  = 4'd6;
  localparam logic [3:0] ST_L2_RD_MIS = 4'd7;
  localparam logic [3:0] ST_L2_WR_MIS = 4'd8;
  localparam logic [3:0] ST_L2_CLEAN  = 4'd9;
  localparam logic [3:0] ST_L2_DIRTY  = 4'd10;
  localparam logic [3:0] ST_L2_RD_ACC = 4'd11;
  localparam logic [3:0] ST_L2_WR_ACC = 4'd12;

  localparam logic [2:0] REG_BLOCK_OFFSET = 3'd0;
  localparam logic [2:0] REG_L1_INDEX     = 3'd1;
  localparam logic [2:0] REG_L2_INDEX     = 3'd2;
  localparam logic [2:0] REG_L1_WAYS      = 3'd3;
  localparam logic [2:0] REG_L2_WAYS      = 3'd4;
  localparam logic [2:0] REG_REPLACE      = 3'd5;

  typedef struct packed {
    logic [2:0] block_offset_bits;
    logic [3:0] l1_index_bits;
    logic [3:0] l2_index_bits;
    logic [2:0] l1_ways_used;
    logic [4:0] l2_ways_used;
    logic       replace_mode;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic do_l2;
    logic do_l1;
    logic mod_start;
    logic mod_sel_l1;
    logic load_out;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic op_access;
    logic l1_hit;
    logic l2_need_rand;
    logic l1_need_rand;
    logic mod_busy;
    logic clr_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/two_level_cache_tag_model.sv */
// flow: a request is accepted in idle and looked up; a statistic read or unused opcode then finishes,
// an L1 hit updates L1, an L1 miss updates L2 then L1; each pseudo-random victim waits on the modulo unit
// one request at a time: in_stall_o is high until the controller returns to idle after each
// a finished result waits in the output register while the next request is taken
// reset: asynchronous active low, then a clearing pass over max(L1_SETS, L2_SETS) set addresses
// (1024 by default) zeroes both set memories before the controller goes idle and takes requests
module two_level_cache_tag_model #(
  parameter int L1_SETS   = 256,
  parameter int L1_WAYS   = 4,
  parameter int L2_SETS   = 1024,
  parameter int L2_WAYS   = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_opcode_i,
  input  logic [31:0] in_address_i,
  input  logic [3:0]  in_stat_select_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_l1_hit_o,
  output logic        out_l2_looked_up_o,
  output logic        out_l2_hit_o,
  output logic [1:0]  out_l1_victim_o,
  output logic [1:0]  out_l2_victim_o,
  output logic [31:0] out_stat_value_o
);
  import tcm_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    wen;

  assign pready = 1'b1;
  assign wen    = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_offset_bits <= 3'd6;
      cfg_q.l1_index_bits     <= 4'd8;
      cfg_q.l2_index_bits     <= 4'd10;
      cfg_q.l1_ways_used      <= 3'd4;
      cfg_q.l2_ways_used      <= 5'd16;
      cfg_q.replace_mode      <= 1'b0;
    end else if (wen) begin
      case (paddr[4:2])
        REG_BLOCK_OFFSET: cfg_q.block_offset_bits <= pwdata[2:0];
        REG_L1_INDEX:     cfg_q.l1_index_bits     <= pwdata[3:0];
        REG_L2_INDEX:     cfg_q.l2_index_bits     <= pwdata[3:0];
        REG_L1_WAYS:      cfg_q.l1_ways_used      <= pwdata[2:0];
        REG_L2_WAYS:      cfg_q.l2_ways_used      <= pwdata[4:0];
        REG_REPLACE:      cfg_q.replace_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BLOCK_OFFSET: prdata = {29'd0, cfg_q.block_offset_bits};
      REG_L1_INDEX:     prdata = {28'd0, cfg_q.l1_index_bits};
      REG_L2_INDEX:     prdata = {28'd0, cfg_q.l2_index_bits};
      REG_L1_WAYS:      prdata = {29'd0, cfg_q.l1_ways_used};
      REG_L2_WAYS:      prdata = {27'd0, cfg_q.l2_ways_used};
      REG_REPLACE:      prdata = {31'd0, cfg_q.replace_mode};
      default:          prdata = '0;
    endcase
  end

  tcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcm_dp #(
    .L1_SETS   (L1_SETS),
    .L1_WAYS   (L1_WAYS),
    .L2_SETS   (L2_SETS),
    .L2_WAYS   (L2_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .status_o           (status),
    .in_opcode_i        (in_opcode_i),
    .in_address_i       (in_address_i),
    .in_stat_select_i   (in_stat_select_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_l1_hit_o       (out_l1_hit_o),
    .out_l2_looked_up_o (out_l2_looked_up_o),
    .out_l2_hit_o       (out_l2_hit_o),
    .out_l1_victim_o    (out_l1_victim_o),
    .out_l2_victim_o    (out_l2_victim_o),
    .out_stat_value_o   (out_stat_value_o)
  );
endmodule

/* rtl/tcm_mod.sv */
module tcm_mod #(
  parameter int DW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [15:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] rem_o
);
  logic          busy_q;
  logic [3:0]    cnt_q;
  logic [15:0]   num_q;
  logic [DW-1:0] rem_q, div_q, rem_d;
  logic [DW:0]   sh;

  always_comb begin
    sh = {rem_q, num_q[15]};
    if (sh >= {1'b0, div_q}) begin
      rem_d = DW'(sh - {1'b0, div_q});
    end else begin
      rem_d = DW'(sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[14:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;
endmodule

/* rtl/tcm_set.sv */
module tcm_set #(
  parameter int WAYS = 4,
  parameter int AW   = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int CW   = $clog2(WAYS + 1)
) (
  input  logic [WAYS*(tcm_pkg::TAG_W+2+AW)-1:0] row_i,
  input  logic [tcm_pkg::TAG_W-1:0]             tag_i,
  input  logic                                  wr_i,
  input  logic [CW-1:0]                         nways_i,
  input  logic                                  rand_mode_i,
  input  logic [AW-1:0]                         rand_way_i,
  output logic                                  hit_o,
  output logic                                  full_o,
  output logic [1:0]                            code_o,
  output logic [WAYS*(tcm_pkg::TAG_W+2+AW)-1:0] row_o
);
  import tcm_pkg::*;

  localparam int WW = TAG_W + 2 + AW;

  logic             valid [WAYS];
  logic             dirty [WAYS];
  logic [AW-1:0]    age   [WAYS];
  logic [TAG_W-1:0] tg    [WAYS];
  logic [WAYS-1:0]  inuse, match, free, cand;
  logic [AW-1:0]    hit_way, free_way, lru_way, w;
  logic             has_free, fh, ff, fl;
  logic [CW-1:0]    ref_age, sat, inc;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      valid[i] = row_i[i*WW];
      dirty[i] = row_i[i*WW+1];
      age[i]   = row_i[i*WW+2 +: AW];
      tg[i]    = row_i[i*WW+2+AW +: TAG_W];
      inuse[i] = (i < int'(nways_i));
      match[i] = inuse[i] && valid[i] && (tg[i] == tag_i);
      free[i]  = inuse[i] && !valid[i];
    end
    for (int i = 0; i < WAYS; i++) begin
      cand[i] = inuse[i];
      for (int j = 0; j < WAYS; j++) begin
        if (inuse[j] && (j < i) && !(age[i] > age[j])) cand[i] = 1'b0;
        if (inuse[j] && (j > i) && (age[i] < age[j])) cand[i] = 1'b0;
      end
    end
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    fh = 1'b0;
    ff = 1'b0;
    fl = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (match[i] && !fh) begin
        hit_way = AW'(i);
        fh = 1'b1;
      end
      if (free[i] && !ff) begin
        free_way = AW'(i);
        ff = 1'b1;
      end
      if (cand[i] && !fl) begin
        lru_way = AW'(i);
        fl = 1'b1;
      end
    end
    hit_o    = fh;
    has_free = ff;
    full_o   = !fh && !ff;
    if (fh) begin
      w = hit_way;
    end else if (ff) begin
      w = free_way;
    end else if (rand_mode_i) begin
      w = rand_way_i;
    end else begin
      w = lru_way;
    end
    ref_age = (!fh && has_free) ? nways_i : CW'(age[w]);
    sat     = nways_i - CW'(1);
    code_o  = full_o ? (dirty[w] ? VIC_DIRTY : VIC_CLEAN) : VIC_NONE;
    row_o   = row_i;
    for (int i = 0; i < WAYS; i++) begin
      inc = CW'(age[i]) + CW'(1);
      if (i == int'(w)) begin
        row_o[i*WW]          = 1'b1;
        row_o[i*WW+1]        = fh ? (dirty[i] | wr_i) : wr_i;
        row_o[i*WW+2 +: AW]  = '0;
        row_o[i*WW+2+AW +: TAG_W] = fh ? tg[i] : tag_i;
      end else if (inuse[i] && valid[i] && (CW'(age[i]) < ref_age)) begin
        row_o[i*WW+2 +: AW] = AW'((inc > sat) ? sat : inc);
      end
    end
  end
endmodule

/* rtl/tcm_ctrl.sv */
module tcm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcm_pkg::status_t status_i,
  output tcm_pkg::cmd_t    cmd_o
);
  import tcm_pkg::*;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_LOOK = 8'b0000_0100,
    S_MOD2 = 8'b0000_1000,
    S_L2   = 8'b0001_0000,
    S_MOD1 = 8'b0010_0000,
    S_L1   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        if (!status_i.op_access) begin
          state_d = S_DONE;
        end else if (status_i.l1_hit) begin
          state_d = S_L1;
        end else if (status_i.l2_need_rand) begin
          cmd_o.mod_start = 1'b1;
          state_d = S_MOD2;
        end else begin
          state_d = S_L2;
        end
      end
      S_MOD2: begin
        if (!status_i.mod_busy) state_d = S_L2;
      end
      S_L2: begin
        cmd_o.do_l2 = 1'b1;
        if (status_i.l1_need_rand) begin
          cmd_o.mod_start  = 1'b1;
          cmd_o.mod_sel_l1 = 1'b1;
          state_d = S_MOD1;
        end else begin
          state_d = S_L1;
        end
      end
      S_MOD1: begin
        if (!status_i.mod_busy) state_d = S_L1;
      end
      S_L1: begin
        cmd_o.do_l1 = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
endmodule

/* rtl/tcm_dp.sv */
module tcm_dp #(
  parameter int L1_SETS   = 256,
  parameter int L1_WAYS   = 4,
  parameter int L2_SETS   = 1024,
  parameter int L2_WAYS   = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcm_pkg::cfg_t    cfg_i,
  input  tcm_pkg::cmd_t    cmd_i,
  output tcm_pkg::status_t status_o,
  input  logic [1:0]       in_opcode_i,
  input  logic [31:0]      in_address_i,
  input  logic [3:0]       in_stat_select_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             out_l1_hit_o,
  output logic             out_l2_looked_up_o,
  output logic             out_l2_hit_o,
  output logic [1:0]       out_l1_victim_o,
  output logic [1:0]       out_l2_victim_o,
  output logic [31:0]      out_stat_value_o
);
  import tcm_pkg::*;

  localparam int AW1   = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int AW2   = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int CW1   = $clog2(L1_WAYS + 1);
  localparam int CW2   = $clog2(L2_WAYS + 1);
  localparam int DW    = (CW1 > CW2) ? CW1 : CW2;
  localparam int IW1   = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int IW2   = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int R1W   = L1_WAYS * (TAG_W + 2 + AW1);
  localparam int R2W   = L2_WAYS * (TAG_W + 2 + AW2);
  localparam int MAXS  = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int CLW   = $clog2(MAXS + 1);
  localparam int NMAX1 = $clog2(L1_SETS + 1) - 1;
  localparam int NMAX2 = $clog2(L2_SETS + 1) - 1;
  localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << ADDR_BITS) - 64'd1);

  logic [R1W-1:0] mem1 [L1_SETS];
  logic [R2W-1:0] mem2 [L2_SETS];
  logic [R1W-1:0] rd1_q, row1_new;
  logic [R2W-1:0] rd2_q, row2_new;

  logic [1:0]       op_q;
  logic [3:0]       sel_q;
  logic [IW1-1:0]   idx1_q, idx1_d;
  logic [IW2-1:0]   idx2_q, idx2_d;
  logic [TAG_W-1:0] tag1_q, tag1_d, tag2_q, tag2_d;
  logic [CLW-1:0]   clr_q;
  logic [15:0]      lfsr_q, lfsr_d, lfsr_step;
  logic [STAT_W-1:0] cnt_q [NUM_STATS];
  logic [NUM_STATS-1:0] inc;

  logic [31:0]    addr_m;
  logic [2:0]     off;
  logic [3:0]     ib1, ib2;
  logic [4:0]     sh1, sh2;
  logic [CW1-1:0] nw1;
  logic [CW2-1:0] nw2;
  logic [DW-1:0]  rem;
  logic           mod_busy;
  logic           wr, access;
  logic           s1_hit, s1_full, s2_hit, s2_full;
  logic [1:0]     s1_code, s2_code;

  logic        res_l1_hit_q, res_l2_look_q, res_l2_hit_q;
  logic [1:0]  res_l1_vic_q, res_l2_vic_q;
  logic [31:0] res_stat_q;
  logic        out_valid_q;

  always_comb begin
    off    = (cfg_i.block_offset_bits < 3'd2) ? 3'd2 : cfg_i.block_offset_bits;
    ib1    = (int'(cfg_i.l1_index_bits) > NMAX1) ? 4'(NMAX1) : cfg_i.l1_index_bits;
    ib2    = (int'(cfg_i.l2_index_bits) > NMAX2) ? 4'(NMAX2) : cfg_i.l2_index_bits;
    if (cfg_i.l1_ways_used == 3'd0) begin
      nw1 = CW1'(1);
    end else if (int'(cfg_i.l1_ways_used) > L1_WAYS) begin
      nw1 = CW1'(L1_WAYS);
    end else begin
      nw1 = CW1'(cfg_i.l1_ways_used);
    end
    if (cfg_i.l2_ways_used == 5'd0) begin
      nw2 = CW2'(1);
    end else if (int'(cfg_i.l2_ways_used) > L2_WAYS) begin
      nw2 = CW2'(L2_WAYS);
    end else begin
      nw2 = CW2'(cfg_i.l2_ways_used);
    end
    addr_m = in_address_i & AMASK;
    sh1    = {2'b0, off} + {1'b0, ib1};
    sh2    = {2'b0, off} + {1'b0, ib2};
    idx1_d = IW1'((addr_m >> off) & ((32'd1 << ib1) - 32'd1));
    idx2_d = IW2'((addr_m >> off) & ((32'd1 << ib2) - 32'd1));
    tag1_d = TAG_W'(addr_m >> sh1);
    tag2_d = TAG_W'(addr_m >> sh2);
  end

  assign wr     = (op_q == OP_WRITE);
  assign access = (op_q == OP_READ) || (op_q == OP_WRITE);

  tcm_set #(.WAYS(L1_WAYS)) u_set1 (
    .row_i       (rd1_q),
    .tag_i       (tag1_q),
    .wr_i        (wr),
    .nways_i     (nw1),
    .rand_mode_i (cfg_i.replace_mode),
    .rand_way_i  (AW1'(rem)),
    .hit_o       (s1_hit),
    .full_o      (s1_full),
    .code_o      (s1_code),
    .row_o       (row1_new)
  );

  tcm_set #(.WAYS(L2_WAYS)) u_set2 (
    .row_i       (rd2_q),
    .tag_i       (tag2_q),
    .wr_i        (wr),
    .nways_i     (nw2),
    .rand_mode_i (cfg_i.replace_mode),
    .rand_way_i  (AW2'(rem)),
    .hit_o       (s2_hit),
    .full_o      (s2_full),
    .code_o      (s2_code),
    .row_o       (row2_new)
  );

  always_comb begin
    lfsr_step = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
    if (cfg_i.replace_mode &&
        ((cmd_i.do_l2 && s2_full) || (cmd_i.do_l1 && s1_full))) begin
      lfsr_d = lfsr_step;
    end else begin
      lfsr_d = lfsr_q;
    end
  end

  tcm_mod #(.DW(DW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (lfsr_d),
    .divisor_i  (cmd_i.mod_sel_l1 ? DW'(nw1) : DW'(nw2)),
    .busy_o     (mod_busy),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      if (int'(clr_q) < L1_SETS) mem1[clr_q[IW1-1:0]] <= '0;
    end else if (cmd_i.do_l1) begin
      mem1[idx1_q] <= row1_new;
    end
    if (cmd_i.accept) rd1_q <= mem1[idx1_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      if (int'(clr_q) < L2_SETS) mem2[clr_q[IW2-1:0]] <= '0;
    end else if (cmd_i.do_l2) begin
      mem2[idx2_q] <= row2_new;
    end
    if (cmd_i.accept) rd2_q <= mem2[idx2_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_opcode_i;
      sel_q  <= in_stat_select_i;
      idx1_q <= idx1_d;
      idx2_q <= idx2_d;
      tag1_q <= tag1_d;
      tag2_q <= tag2_d;
    end
  end

  always_comb begin
    inc = '0;
    if (cmd_i.look && access) begin
      inc[ST_TOTAL] = 1'b1;
      inc[wr ? ST_WRITES : ST_READS] = 1'b1;
    end
    if (cmd_i.do_l2) begin
      inc[wr ? ST_L1_WR_MIS : ST_L1_RD_MIS] = 1'b1;
      inc[wr ? ST_L2_WR_ACC : ST_L2_RD_ACC] = 1'b1;
      if (!s2_hit) inc[wr ? ST_L2_WR_MIS : ST_L2_RD_MIS] = 1'b1;
      if (s2_code == VIC_CLEAN) inc[ST_L2_CLEAN] = 1'b1;
      if (s2_code == VIC_DIRTY) inc[ST_L2_DIRTY] = 1'b1;
    end
    if (cmd_i.do_l1) begin
      if (s1_code == VIC_CLEAN) inc[ST_L1_CLEAN] = 1'b1;
      if (s1_code == VIC_DIRTY) inc[ST_L1_DIRTY] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_STATS; k++) cnt_q[k] <= '0;
    end else begin
      if (cmd_i.clr && (int'(clr_q) != MAXS)) clr_q <= clr_q + CLW'(1);
      lfsr_q <= lfsr_d;
      for (int k = 0; k < NUM_STATS; k++) begin
        if (inc[k] && (cnt_q[k] != '1)) cnt_q[k] <= cnt_q[k] + STAT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_l1_hit_q  <= 1'b0;
      res_l2_look_q <= 1'b0;
      res_l2_hit_q  <= 1'b0;
      res_l1_vic_q  <= VIC_NONE;
      res_l2_vic_q  <= VIC_NONE;
      res_stat_q    <= '0;
    end
    if (cmd_i.look && (op_q == OP_STAT) && (int'(sel_q) < NUM_STATS)) begin
      res_stat_q <= cnt_q[sel_q];
    end
    if (cmd_i.do_l2) begin
      res_l2_look_q <= 1'b1;
      res_l2_hit_q  <= s2_hit;
      res_l2_vic_q  <= s2_code;
    end
    if (cmd_i.do_l1) begin
      res_l1_hit_q <= s1_hit;
      res_l1_vic_q <= s1_code;
    end
    if (cmd_i.load_out) begin
      out_l1_hit_o       <= res_l1_hit_q;
      out_l2_looked_up_o <= res_l2_look_q;
      out_l2_hit_o       <= res_l2_hit_q;
      out_l1_victim_o    <= res_l1_vic_q;
      out_l2_victim_o    <= res_l2_vic_q;
      out_stat_value_o   <= res_stat_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o              = '0;
    status_o.op_access    = access;
    status_o.l1_hit       = s1_hit;
    status_o.l2_need_rand = s2_full && cfg_i.replace_mode;
    status_o.l1_need_rand = s1_full && cfg_i.replace_mode;
    status_o.mod_busy     = mod_busy;
    status_o.clr_done     = (int'(clr_q) == MAXS);
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end
endmodule

/* rtl/tcm_checker.sv */
module tcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_l1_hit_o,
  input logic        out_l2_looked_up_o,
  input logic        out_l2_hit_o,
  input logic [1:0]  out_l1_victim_o,
  input logic [1:0]  out_l2_victim_o,
  input logic [31:0] out_stat_value_o
);
  import tcm_pkg::*;

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_stat_value_o))
    else $error("stalled result changed");

  a_l1_hit_no_l2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_l1_hit_o |->
      !out_l2_looked_up_o && !out_l2_hit_o && (out_l2_victim_o == VIC_NONE))
    else $error("l2 activity reported on an l1 hit");

  a_l2_hit_looked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_l2_hit_o || (out_l2_victim_o != VIC_NONE)) |->
      out_l2_looked_up_o && !out_l1_hit_o)
    else $error("l2 result without l2 lookup");

  a_stat_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_stat_value_o != 32'd0) |->
      !out_l1_hit_o && !out_l2_looked_up_o && (out_l1_victim_o == VIC_NONE))
    else $error("statistic read with access flags");
endmodule

bind two_level_cache_tag_model tcm_checker u_tcm_checker (.*);

/* tb/two_level_cache_tag_model_checker.sv */
module two_level_cache_tag_model_checker #(
  parameter int L1_SETS = 256,
  parameter int L1_WAYS = 4,
  parameter int L2_SETS = 1024,
  parameter int L2_WAYS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  in_opcode_i,
  input  logic [31:0] in_address_i,
  input  logic [3:0]  in_stat_select_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        out_l1_hit_o,
  input  logic        out_l2_looked_up_o,
  input  logic        out_l2_hit_o,
  input  logic [1:0]  out_l1_victim_o,
  input  logic [1:0]  out_l2_victim_o,
  input  logic [31:0] out_stat_value_o,
  output int          fail_count,
  output int          pending_count
);
  import tcm_pkg::*;

  localparam int DEPTH = L2_SETS * L2_WAYS;
  localparam int L1_IB_MAX = $clog2(L1_SETS + 1) - 1;
  localparam int L2_IB_MAX = $clog2(L2_SETS + 1) - 1;

  typedef struct packed {
    logic        l1_hit;
    logic        l2_looked_up;
    logic        l2_hit;
    logic [1:0]  l1_victim;
    logic [1:0]  l2_victim;
    logic [31:0] stat_value;
  } cache_result_t;

  cache_result_t result_q[$];

  logic [31:0] tag_mem [0:1][0:DEPTH-1];
  bit          valid_mem [0:1][0:DEPTH-1];
  bit          dirty_mem [0:1][0:DEPTH-1];
  int          age_mem [0:1][0:DEPTH-1];
  logic [15:0] lfsr;
  logic [31:0] stats [0:NUM_STATS-1];
  cfg_t        cfg;

  assign pending_count = result_q.size();

  task automatic clear_model();
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        tag_mem[l][i] = '0;
        valid_mem[l][i] = 0;
        dirty_mem[l][i] = 0;
        age_mem[l][i] = 0;
      end
    end
    for (int i = 0; i < NUM_STATS; i++) stats[i] = '0;
    lfsr = LFSR_SEED;
    cfg.block_offset_bits = 3'd6;
    cfg.l1_index_bits = 4'd8;
    cfg.l2_index_bits = 4'd10;
    cfg.l1_ways_used = 3'd4;
    cfg.l2_ways_used = 5'd16;
    cfg.replace_mode = 1'b0;
  endtask

  task automatic bump(input logic [3:0] k);
    if (stats[k] != 32'hFFFF_FFFF) stats[k] = stats[k] + 1;
  endtask

  task automatic refresh_ages(input int lvl, input int base, input int ways, input int w,
                              input int ref_age);
    int a;
    for (int i = 0; i < ways; i++) begin
      if (i != w && valid_mem[lvl][base+i] && age_mem[lvl][base+i] < ref_age) begin
        a = age_mem[lvl][base+i] + 1;
        age_mem[lvl][base+i] = (a > ways - 1) ? ways - 1 : a;
      end
    end
    age_mem[lvl][base+w] = 0;
  endtask

  task automatic lookup_fill(input int lvl, input int base, input int ways,
                             input logic [31:0] t, input bit wr,
                             output bit hit, output logic [1:0] code);
    int w;
    int ref_age;
    hit = 0;
    code = VIC_NONE;
    for (int i = 0; i < ways; i++) begin
      if (!hit && valid_mem[lvl][base+i] && tag_mem[lvl][base+i] == t) begin
        hit = 1;
        refresh_ages(lvl, base, ways, i, age_mem[lvl][base+i]);
        if (wr) dirty_mem[lvl][base+i] = 1;
      end
    end
    if (!hit) begin
      w = ways;
      for (int i = ways - 1; i >= 0; i--) if (!valid_mem[lvl][base+i]) w = i;
      if (w < ways) begin
        ref_age = ways;
      end else begin
        if (cfg.replace_mode) begin
          w = int'(lfsr) % ways;
          lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
        end else begin
          w = 0;
          for (int i = 1; i < ways; i++)
            if (age_mem[lvl][base+i] > age_mem[lvl][base+w]) w = i;
        end
        ref_age = age_mem[lvl][base+w];
        code = dirty_mem[lvl][base+w] ? VIC_DIRTY : VIC_CLEAN;
      end
      tag_mem[lvl][base+w] = t;
      valid_mem[lvl][base+w] = 1;
      dirty_mem[lvl][base+w] = wr;
      refresh_ages(lvl, base, ways, w, ref_age);
    end
  endtask

  task automatic predict_cache(input logic [1:0] op, input logic [31:0] addr,
                               input logic [3:0] sel, output cache_result_t r);
    int off, ib1, ib2, w1, w2, base1, base2;
    bit wr, h1, h2;
    logic [31:0] t1;
    logic [1:0] v1, v2;
    r = '0;
    h2 = 0;
    v2 = VIC_NONE;
    if (op == OP_STAT) begin
      r.stat_value = (sel < NUM_STATS) ? stats[sel] : '0;
    end else if (op == OP_READ || op == OP_WRITE) begin
      wr = (op == OP_WRITE);
      off = (cfg.block_offset_bits < 2) ? 2 : cfg.block_offset_bits;
      ib1 = (cfg.l1_index_bits > L1_IB_MAX) ? L1_IB_MAX : cfg.l1_index_bits;
      ib2 = (cfg.l2_index_bits > L2_IB_MAX) ? L2_IB_MAX : cfg.l2_index_bits;
      w1 = (cfg.l1_ways_used == 0) ? 1 :
           (cfg.l1_ways_used > L1_WAYS) ? L1_WAYS : cfg.l1_ways_used;
      w2 = (cfg.l2_ways_used == 0) ? 1 :
           (cfg.l2_ways_used > L2_WAYS) ? L2_WAYS : cfg.l2_ways_used;
      bump(ST_TOTAL);
      bump(wr ? ST_WRITES : ST_READS);
      base1 = int'((addr >> off) & ((32'd1 << ib1) - 1)) * L1_WAYS;
      t1 = addr >> (off + ib1);
      h1 = 0;
      for (int i = 0; i < w1; i++)
        if (valid_mem[0][base1+i] && tag_mem[0][base1+i] == t1) h1 = 1;
      if (!h1) begin
        bump(wr ? ST_L1_WR_MIS : ST_L1_RD_MIS);
        bump(wr ? ST_L2_WR_ACC : ST_L2_RD_ACC);
        base2 = int'((addr >> off) & ((32'd1 << ib2) - 1)) * L2_WAYS;
        lookup_fill(1, base2, w2, addr >> (off + ib2), wr, h2, v2);
        if (!h2) bump(wr ? ST_L2_WR_MIS : ST_L2_RD_MIS);
        if (v2 == VIC_CLEAN) bump(ST_L2_CLEAN);
        if (v2 == VIC_DIRTY) bump(ST_L2_DIRTY);
      end
      lookup_fill(0, base1, w1, t1, wr, h1, v1);
      if (v1 == VIC_CLEAN) bump(ST_L1_CLEAN);
      if (v1 == VIC_DIRTY) bump(ST_L1_DIRTY);
      r.l1_hit = h1;
      r.l2_looked_up = !h1;
      r.l2_hit = h2;
      r.l1_victim = v1;
      r.l2_victim = v2;
    end
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t r;
    if (!rst_ni) begin
      fail_count = 0;
      clear_model();
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_BLOCK_OFFSET: cfg.block_offset_bits = pwdata[2:0];
          REG_L1_INDEX:     cfg.l1_index_bits = pwdata[3:0];
          REG_L2_INDEX:     cfg.l2_index_bits = pwdata[3:0];
          REG_L1_WAYS:      cfg.l1_ways_used = pwdata[2:0];
          REG_L2_WAYS:      cfg.l2_ways_used = pwdata[4:0];
          REG_REPLACE:      cfg.replace_mode = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        predict_cache(in_opcode_i, in_address_i, in_stat_select_i, r);
        result_q.push_back(r);
      end
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          r = result_q.pop_front();
          if (out_l1_hit_o !== r.l1_hit) report("l1_hit", out_l1_hit_o, r.l1_hit);
          if (out_l2_looked_up_o !== r.l2_looked_up)
            report("l2_looked_up", out_l2_looked_up_o, r.l2_looked_up);
          if (out_l2_hit_o !== r.l2_hit) report("l2_hit", out_l2_hit_o, r.l2_hit);
          if (out_l1_victim_o !== r.l1_victim)
            report("l1_victim", out_l1_victim_o, r.l1_victim);
          if (out_l2_victim_o !== r.l2_victim)
            report("l2_victim", out_l2_victim_o, r.l2_victim);
          if (out_stat_value_o !== r.stat_value)
            report("stat_value", out_stat_value_o, r.stat_value);
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  import tcm_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_opcode_i = OP_READ;
  logic [31:0] in_address_i = '0;
  logic [3:0]  in_stat_select_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_l1_hit_o;
  logic        out_l2_looked_up_o;
  logic        out_l2_hit_o;
  logic [1:0]  out_l1_victim_o;
  logic [1:0]  out_l2_victim_o;
  logic [31:0] out_stat_value_o;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int off_now = 6;
  int span_now = 16;

  two_level_cache_tag_model dut (.*);

  two_level_cache_tag_model_checker checker_i (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("two_level_cache_tag_model: mismatch");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
                              input logic [3:0] sel);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_opcode_i <= op;
    in_address_i <= addr;
    in_stat_select_i <= sel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_config(input int off, input int ib1, input int ib2, input int w1,
                            input int w2, input int mode);
    reg_write(REG_BLOCK_OFFSET, off);
    reg_write(REG_L1_INDEX, ib1);
    reg_write(REG_L2_INDEX, ib2);
    reg_write(REG_L1_WAYS, w1);
    reg_write(REG_L2_WAYS, w2);
    reg_write(REG_REPLACE, mode);
    off_now = (off < 2) ? 2 : off;
    span_now = off_now + ((ib2 > 10) ? 10 : ib2);
  endtask

  task automatic random_request();
    int pick;
    logic [1:0] op;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    op = (pick < 45) ? OP_READ : (pick < 85) ? OP_WRITE : (pick < 95) ? OP_STAT : OP_IGNORED;
    if ($urandom_range(0, 9) == 0) addr = $urandom;
    else addr = (32'($urandom_range(0, 11)) << span_now)
              | (32'($urandom_range(0, 7)) << off_now) | 32'($urandom_range(0, 3));
    send_request(op, addr, 4'($urandom_range(0, 15)));
  endtask

  initial begin
    int cfgs [8][6];
    cfgs = '{'{6, 8, 10, 4, 16, 0}, '{0, 0, 0, 0, 0, 1}, '{7, 15, 15, 7, 31, 0},
             '{2, 1, 2, 2, 3, 1}, '{3, 2, 3, 4, 16, 1}, '{4, 1, 1, 3, 5, 0},
             '{5, 0, 2, 1, 2, 1}, '{2, 2, 4, 4, 8, 0}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill one set past its ways to get clean and dirty evictions
    send_request(OP_READ, 32'h0, 4'd0);
    send_request(OP_WRITE, 32'h0, 4'd0);
    send_request(OP_WRITE, 32'hFFFF_FFFF, 4'd0);
    send_request(OP_READ, 32'hFFFF_FFFF, 4'd0);
    for (int i = 1; i <= 5; i++) send_request(OP_READ, 32'(i) << 14, 4'd0);
    send_request(OP_WRITE, 32'h0000_4000, 4'd0);
    for (int i = 6; i <= 21; i++) send_request(OP_READ, 32'(i) << 16, 4'd0);
    send_request(OP_READ, 32'h0, 4'd0);
    send_request(OP_STAT, 32'hFFFF_FFFF, ST_TOTAL);
    send_request(OP_STAT, 32'h0, ST_L1_DIRTY);
    send_request(OP_STAT, 32'h0, ST_L2_WR_ACC);
    send_request(OP_STAT, 32'h0, 4'd15);
    send_request(OP_IGNORED, 32'hFFFF_FFFF, 4'd15);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_config(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4], cfgs[p][5]);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 73; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 73; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int n = 0; n < 150; n++) begin
        if (p == 3 && n == 75) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_count != 0) @(posedge clk_i);
        end
        random_request();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("two_level_cache_tag_model: match");
    end else begin
      $display("two_level_cache_tag_model: mismatch");
    end
    $finish;
  end

endmodule
